// ----- rtl/core/sdbm_pkg.sv -----
// ----------------------------------------------------------------------------
// sdbm_pkg
// Shared widths, constants and types for the sdbm string hash to bucket index
// block.
// ----------------------------------------------------------------------------
package sdbm_pkg;

	// Field and state widths.
	localparam int BYTE_W = 8;
	localparam int HASH_W = 64;
	localparam int IDX_W  = 31;

	// Shift amounts of the multiply by 65599.
	localparam int SHIFT_LO = 6;
	localparam int SHIFT_HI = 16;

	// Table size after reset.
	localparam logic [IDX_W-1:0] TS_RESET = IDX_W'(1024);

	// Queue between the hash front end and the modulo back end.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Step counter of the bit-serial modulo unit.
	localparam int STEP_W = $clog2(HASH_W);

	// Queue status seen by its producer and consumer.
	typedef struct packed {
		logic full;
		logic valid;
	} q_stat_t;

endpackage

// ----- rtl/core/sdbm_if.sv -----
// ----------------------------------------------------------------------------
// sdbm channel interfaces
// Valid/ready channels for key bytes, bucket indexes and the table size
// register write.
// ----------------------------------------------------------------------------

// Key byte channel.
interface sdbm_key_if;
	logic                        valid;
	logic                        ready;
	logic [sdbm_pkg::BYTE_W-1:0] key_byte;
	logic                        last_byte;

	modport source (output valid, output key_byte, output last_byte, input ready);
	modport sink   (input valid, input key_byte, input last_byte, output ready);
endinterface

// Bucket index channel.
interface sdbm_idx_if;
	logic                       valid;
	logic                       ready;
	logic [sdbm_pkg::IDX_W-1:0] bucket_index;

	modport source (output valid, output bucket_index, input ready);
	modport sink   (input valid, input bucket_index, output ready);
endinterface

// Table size register write channel.
interface sdbm_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sdbm_pkg::IDX_W-1:0] table_size;

	modport source (output valid, output table_size, input ready);
	modport sink   (input valid, input table_size, output ready);
endinterface

// ----- rtl/core/sdbm_front.sv -----
// ----------------------------------------------------------------------------
// sdbm_front
// Accepts key bytes, folds them into the running hash and pushes the final
// hash of each key into the queue.
// ----------------------------------------------------------------------------
module sdbm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sdbm_pkg::BYTE_W-1:0]   key_byte,
	input  logic                          last_byte,
	input  sdbm_pkg::q_stat_t             q_stat,
	output logic                          push,
	output logic [sdbm_pkg::HASH_W-1:0]   push_hash
);

	logic [sdbm_pkg::HASH_W-1:0] hash_q;
	logic [sdbm_pkg::HASH_W-1:0] hash_upd;
	logic [sdbm_pkg::HASH_W-1:0] hash_nx;
	logic                        accept;

	// Bytes are taken whenever the queue can hold a finished key.
	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;

	// hash * 65599 + byte, as two shifts, two adds and a subtract.
	assign hash_upd = (hash_q << sdbm_pkg::SHIFT_LO) + (hash_q << sdbm_pkg::SHIFT_HI)
		- hash_q + sdbm_pkg::HASH_W'(key_byte);

	// A zero byte leaves the hash as it is.
	assign hash_nx = (key_byte != '0) ? hash_upd : hash_q;

	assign push      = accept && last_byte;
	assign push_hash = hash_nx;

	// Running hash, cleared after each key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (accept) begin
			hash_q <= last_byte ? '0 : hash_nx;
		end
	end

endmodule

// ----- rtl/core/sdbm_queue.sv -----
// ----------------------------------------------------------------------------
// sdbm_queue
// Short first-in first-out queue of finished key hashes between the front and
// back ends.
// ----------------------------------------------------------------------------
module sdbm_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [sdbm_pkg::HASH_W-1:0]   push_hash,
	input  logic                          pop,
	output logic [sdbm_pkg::HASH_W-1:0]   pop_hash,
	output sdbm_pkg::q_stat_t             q_stat
);

	logic [sdbm_pkg::HASH_W-1:0]  slot_q [sdbm_pkg::Q_DEPTH];
	logic [sdbm_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [sdbm_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [sdbm_pkg::Q_CNT_W-1:0] fill_q;
	logic                         do_push;
	logic                         do_pop;

	assign q_stat.full  = (fill_q == sdbm_pkg::Q_CNT_W'(sdbm_pkg::Q_DEPTH));
	assign q_stat.valid = (fill_q != '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && q_stat.valid;
	assign pop_hash     = slot_q[rd_ptr_q];

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_hash;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/sdbm_mod.sv -----
// ----------------------------------------------------------------------------
// sdbm_mod
// Back end: reduces a 64-bit hash modulo the table size, one dividend bit per
// cycle (the last one waits for a free output register) and holds the bucket index.
// ----------------------------------------------------------------------------
module sdbm_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sdbm_pkg::IDX_W-1:0]    table_size,
	input  sdbm_pkg::q_stat_t             q_stat,
	input  logic [sdbm_pkg::HASH_W-1:0]   pop_hash,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdbm_pkg::IDX_W-1:0]    bucket_index
);

	logic                          busy_q;
	logic [sdbm_pkg::STEP_W-1:0]   step_q;
	logic [sdbm_pkg::HASH_W-1:0]   dvd_q;
	logic [sdbm_pkg::IDX_W-1:0]    rem_q;
	logic                          out_valid_q;
	logic [sdbm_pkg::IDX_W-1:0]    out_data_q;
	logic [sdbm_pkg::IDX_W:0]      rem_sh;
	logic [sdbm_pkg::IDX_W:0]      rem_sub;
	logic [sdbm_pkg::IDX_W:0]      rem_nx;
	logic                          last_step;
	logic                          out_free;
	logic                          advance;

	// Take a new hash whenever the divider is free.
	assign pop = !busy_q && q_stat.valid;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	assign rem_sh  = {rem_q, dvd_q[sdbm_pkg::HASH_W-1]};
	assign rem_sub = rem_sh - {1'b0, table_size};
	assign rem_nx  = (rem_sh >= {1'b0, table_size}) ? rem_sub : rem_sh;

	// The last step waits until the output register can take the result.
	assign last_step = (step_q == sdbm_pkg::STEP_W'(sdbm_pkg::HASH_W - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign advance   = busy_q && (!last_step || out_free);

	assign out_valid    = out_valid_q;
	assign bucket_index = out_data_q;

	// Divider control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (advance) begin
			step_q <= step_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Dividend and partial remainder.
	always_ff @(posedge clk) begin
		if (pop) begin
			dvd_q <= pop_hash;
			rem_q <= '0;
		end else if (advance) begin
			dvd_q <= {dvd_q[sdbm_pkg::HASH_W-2:0], 1'b0};
			rem_q <= rem_nx[sdbm_pkg::IDX_W-1:0];
		end
	end

	// Output register; a zero table size gives index zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_step) begin
			out_data_q <= (table_size == '0) ? '0 : rem_nx[sdbm_pkg::IDX_W-1:0];
		end
	end

endmodule

// ----- rtl/core/sdbm_string_hash_to_index.sv -----
// Path: a byte is folded into the running hash; the final hash of each key passes
// through the queue into the bit-serial divider and on to the output register.
// Throughput: one byte per cycle while the queue is not full; the modulo unit takes a new
// hash only once the last one is done, and a two-entry queue absorbs bursts of short keys.
// Reset: arst_n clears the running hash, queue, divider and output; table size is 1024.
// ----------------------------------------------------------------------------
// sdbm_string_hash_to_index
// Streams key bytes into an sdbm hash and returns the hash modulo the
// configured table size as a bucket index.
// ----------------------------------------------------------------------------
module sdbm_string_hash_to_index (
	input  logic     clk,
	input  logic     arst_n,
	sdbm_key_if.sink key_in,
	sdbm_idx_if.source idx_out,
	sdbm_cfg_if.sink cfg
);

	logic [sdbm_pkg::IDX_W-1:0]  table_size_q;
	sdbm_pkg::q_stat_t           q_stat;
	logic                        push;
	logic [sdbm_pkg::HASH_W-1:0] push_hash;
	logic                        pop;
	logic [sdbm_pkg::HASH_W-1:0] pop_hash;

	// Table size register; the user must write it only while the block is idle; the block itself does not enforce this.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= sdbm_pkg::TS_RESET;
		end else if (cfg.valid) begin
			table_size_q <= cfg.table_size;
		end
	end

	sdbm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (key_in.valid),
		.in_ready  (key_in.ready),
		.key_byte  (key_in.key_byte),
		.last_byte (key_in.last_byte),
		.q_stat    (q_stat),
		.push      (push),
		.push_hash (push_hash)
	);

	sdbm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_hash (push_hash),
		.pop       (pop),
		.pop_hash  (pop_hash),
		.q_stat    (q_stat)
	);

	sdbm_mod u_mod (
		.clk          (clk),
		.arst_n       (arst_n),
		.table_size   (table_size_q),
		.q_stat       (q_stat),
		.pop_hash     (pop_hash),
		.pop          (pop),
		.out_valid    (idx_out.valid),
		.out_ready    (idx_out.ready),
		.bucket_index (idx_out.bucket_index)
	);

endmodule

// ----- rtl/core/sdbm_checker.sv -----
// ----------------------------------------------------------------------------
// sdbm_checker
// Port-level checks on the bucket index channel, bound to the top level.
// ----------------------------------------------------------------------------
module sdbm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       last_byte,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [sdbm_pkg::IDX_W-1:0] cfg_table_size,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sdbm_pkg::IDX_W-1:0] bucket_index
);

	logic [sdbm_pkg::IDX_W-1:0] ts_q;
	logic [3:0]                 pend_q;
	logic                       key_done;
	logic                       out_beat;

	assign key_done = in_valid && in_ready && last_byte;
	assign out_beat = out_valid && out_ready;

	// Shadow of the table size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= sdbm_pkg::TS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ts_q <= cfg_table_size;
		end
	end

	// Keys taken whose index has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (key_done && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !key_done) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	// A stalled beat stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("bucket index beat withdrawn while stalled");

	// A stalled beat keeps its index.
	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(bucket_index))
		else $error("bucket index changed while stalled");

	// Every index belongs to a finished key.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("bucket index without a finished key");

	// The index lies inside the table when the table size is not zero.
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ts_q != '0 |-> bucket_index < ts_q)
		else $error("bucket index not below table size");

endmodule

bind sdbm_string_hash_to_index sdbm_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (key_in.valid),
	.in_ready       (key_in.ready),
	.last_byte      (key_in.last_byte),
	.cfg_valid      (cfg.valid),
	.cfg_ready      (cfg.ready),
	.cfg_table_size (cfg.table_size),
	.out_valid      (idx_out.valid),
	.out_ready      (idx_out.ready),
	.bucket_index   (idx_out.bucket_index)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sdbm_string_hash_to_index. Keys are streamed one
// byte per beat, an sdbm hash with the bucket reduction is kept alongside the
// block, and every bucket index beat is compared with the oldest predicted one.
// Runs directed keys, table size extremes, a long output hold-off and three
// random phases with different idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int  DRAIN_CYC  = 80;
	localparam time RUN_LIMIT  = 5ms;
	localparam int  HOLD_CYC   = 400;

	logic clk = 1'b0;
	logic arst_n;

	sdbm_key_if key_bus ();
	sdbm_idx_if idx_bus ();
	sdbm_cfg_if cfg_bus ();

	sdbm_string_hash_to_index u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_bus),
		.idx_out (idx_bus),
		.cfg     (cfg_bus)
	);

	always #5 clk = ~clk;

	// Bench copy of the block state and register.
	logic [sdbm_pkg::HASH_W-1:0] key_hash   = '0;
	logic [sdbm_pkg::IDX_W-1:0]  bucket_div = sdbm_pkg::TS_RESET;
	logic [sdbm_pkg::IDX_W-1:0]  pending_buckets[$];
	logic [sdbm_pkg::IDX_W-1:0]  bucket_exp;

	int src_idle_pct = 0;
	int snk_idle_pct = 0;
	int hold_left    = 0;
	int err_cnt      = 0;
	int bytes_sent   = 0;
	int keys_sent    = 0;
	int buckets_seen = 0;
	int size_writes  = 0;

	// Fold one accepted byte into the hash; on the last byte, reduce it to a
	// bucket index and start a fresh key.
	function automatic void sdbm_absorb(input logic [sdbm_pkg::BYTE_W-1:0] b,
			input logic is_last);
		if (b != '0)
			key_hash = key_hash * 64'd65599 + sdbm_pkg::HASH_W'(b);
		if (is_last) begin
			if (bucket_div == '0)
				pending_buckets.push_back('0);
			else
				pending_buckets.push_back(sdbm_pkg::IDX_W'(key_hash
					% sdbm_pkg::HASH_W'(bucket_div)));
			key_hash = '0;
		end
	endfunction

	// Send one key byte; valid is left high after the beat so that the next
	// byte can follow in the very next cycle.
	task automatic send_key_byte(input logic [sdbm_pkg::BYTE_W-1:0] b, input logic is_last);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			key_bus.valid <= 1'b0;
			@(negedge clk);
		end
		key_bus.valid     <= 1'b1;
		key_bus.key_byte  <= b;
		key_bus.last_byte <= is_last;
		do @(posedge clk); while (!key_bus.ready);
		sdbm_absorb(b, is_last);
		bytes_sent++;
		if (is_last)
			keys_sent++;
	endtask

	// Stop offering bytes and wait until every predicted bucket has come out.
	task automatic drain_buckets();
		@(negedge clk);
		key_bus.valid <= 1'b0;
		while (pending_buckets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// Write the table size register while the block is idle.
	task automatic write_table_size(input logic [sdbm_pkg::IDX_W-1:0] size_val);
		drain_buckets();
		@(negedge clk);
		cfg_bus.valid      <= 1'b1;
		cfg_bus.table_size <= size_val;
		do @(posedge clk); while (!cfg_bus.ready);
		bucket_div = size_val;
		size_writes++;
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	// Random key: mostly short, now and then long enough to wrap the hash,
	// with a sprinkling of zero bytes.
	task automatic send_random_key();
		int                          len;
		logic [sdbm_pkg::BYTE_W-1:0] b;
		len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
		for (int i = 0; i < len; i++) begin
			b = ($urandom_range(9) == 0) ? '0 : sdbm_pkg::BYTE_W'($urandom_range(255));
			send_key_byte(b, i == len - 1);
		end
	endtask

	// Empty key, single bytes at the extremes, zero bytes inside a key and a
	// long key of 0xFF that wraps the 64-bit hash.
	task automatic test_directed_keys();
		send_key_byte(8'h00, 1'b1);
		send_key_byte(8'hFF, 1'b1);
		send_key_byte(8'h01, 1'b1);
		send_key_byte(8'h61, 1'b0);
		send_key_byte(8'h00, 1'b0);
		send_key_byte(8'h62, 1'b1);
		send_key_byte(8'hAA, 1'b0);
		send_key_byte(8'h55, 1'b0);
		send_key_byte(8'h00, 1'b1);
		for (int i = 0; i < 6; i++)
			send_key_byte(8'hFF, i == 5);
		drain_buckets();
	endtask

	// Smallest, zero and largest table sizes, one key under each.
	task automatic test_table_size_extremes();
		logic [sdbm_pkg::IDX_W-1:0] sizes[3];
		sizes = '{sdbm_pkg::IDX_W'(1), '0, {sdbm_pkg::IDX_W{1'b1}}};
		foreach (sizes[i]) begin
			write_table_size(sizes[i]);
			send_key_byte(8'h7A, 1'b0);
			send_key_byte(8'h80, 1'b0);
			send_key_byte(8'h3C, 1'b1);
		end
		drain_buckets();
	endtask

	// Hold the output off for a long stretch while short keys keep coming, so
	// the queue fills and the input stalls.
	task automatic test_output_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_table_size(sdbm_pkg::IDX_W'(1021));
		hold_left = HOLD_CYC;
		for (int i = 0; i < 8; i++)
			send_key_byte(sdbm_pkg::BYTE_W'($urandom_range(1, 255)), 1'b1);
		drain_buckets();
	endtask

	// One random phase with its own table size and idle pattern.
	task automatic test_random_phase(input logic [sdbm_pkg::IDX_W-1:0] size_val,
			input int src_pct, input int snk_pct, input int n_bytes);
		int stop_at;
		write_table_size(size_val);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_key();
		drain_buckets();
	endtask

	// Output side: ready follows the idle pattern, or stays low while a
	// hold-off is counting down.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			idx_bus.ready <= 1'b0;
			hold_left--;
		end else begin
			idx_bus.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Compare each bucket index beat with the oldest prediction.
	always @(posedge clk) begin
		if (idx_bus.valid === 1'b1 && idx_bus.ready === 1'b1) begin
			if (pending_buckets.size() == 0) begin
				$display("%0t: bucket index %0d with none expected", $time,
					idx_bus.bucket_index);
				err_cnt++;
			end else begin
				bucket_exp = pending_buckets.pop_front();
				buckets_seen++;
				if (idx_bus.bucket_index !== bucket_exp) begin
					$display("%0t: bucket_index expected %0d, got %0d", $time,
						bucket_exp, idx_bus.bucket_index);
					err_cnt++;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		arst_n             = 1'b0;
		key_bus.valid      = 1'b0;
		key_bus.key_byte   = '0;
		key_bus.last_byte  = 1'b0;
		idx_bus.ready      = 1'b0;
		cfg_bus.valid      = 1'b0;
		cfg_bus.table_size = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_keys();
		test_table_size_extremes();
		test_output_backpressure();
		test_random_phase(sdbm_pkg::IDX_W'($urandom_range(1, 1000)), 22, 59, 330);
		test_random_phase(sdbm_pkg::IDX_W'(1) << $urandom_range(0, 30), 59, 22, 330);
		test_random_phase(sdbm_pkg::IDX_W'($urandom_range(1, 32'h7FFF_FFFF)), 0, 0, 340);

		drain_buckets();
		$display("Covered %0d key bytes in %0d keys, %0d bucket indexes checked,",
			bytes_sent, keys_sent, buckets_seen);
		$display("%0d table size writes including zero, one and the largest size.",
			size_writes);
		if (err_cnt == 0)
			$display("[sdbm_string_hash_to_index] OK");
		else
			$display("[sdbm_string_hash_to_index] ERROR");
		$finish;
	end

	// Watchdog.
	initial begin
		#(RUN_LIMIT);
		$display("Timeout with %0d bucket indexes outstanding", pending_buckets.size());
		$display("[sdbm_string_hash_to_index] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/sdbm_pkg.sv
rtl/core/sdbm_if.sv
rtl/core/sdbm_front.sv
rtl/core/sdbm_queue.sv
rtl/core/sdbm_mod.sv
rtl/core/sdbm_string_hash_to_index.sv
rtl/core/sdbm_checker.sv
dv/tb_top.sv
